/* design/beta_spline_segment_eval_assert.svh */
// Assertion macros used by the beta-spline evaluator checker.
// Relies on signals named clk and rst in the module that uses them.
`ifndef BETA_SPLINE_SEGMENT_EVAL_ASSERT_SVH
`define BETA_SPLINE_SEGMENT_EVAL_ASSERT_SVH

// same-cycle implication
`define BSSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bsse check failed");

// next-cycle implication
`define BSSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bsse check failed");

`endif

/* design/bsse_pkg.sv */
// Types, widths and rounding helpers for the beta-spline segment evaluator.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bsse_pkg;

  localparam int NUM_W      = 56;  // signed basis numerator
  localparam int DEN_W      = 52;  // basis denominator delta
  localparam int FRAC_STEPS = 29;  // quotient bits below the binary point
  localparam int Q_W        = 34;  // kept quotient bits before rounding
  localparam int HW         = 38;  // Horner accumulator / weight width
  localparam int MB_W       = 33;  // second multiplier operand
  localparam int PROD_W     = HW + MB_W;
  localparam int SUM_W      = 72;
  localparam int CNT_W      = 7;

  typedef struct packed {
    logic signed [31:0] p1_x;
    logic signed [31:0] p1_y;
    logic signed [31:0] p2_x;
    logic signed [31:0] p2_y;
    logic signed [31:0] p3_x;
    logic signed [31:0] p3_y;
    logic signed [31:0] p4_x;
    logic signed [31:0] p4_y;
  } bsse_in_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] slope_x;
    logic signed [31:0] slope_y;
    logic [5:0]         sample_index;
    logic               last_sample;
  } bsse_out_t;

  // arithmetic shift right by s, rounding half away from zero
  function automatic logic signed [SUM_W-1:0] rnd_shift(input logic signed [SUM_W-1:0] v,
                                                        input int unsigned s);
    logic signed [SUM_W-1:0] half;
    half = 72'sd1 <<< (s - 1);
    if (v >= 0) begin
      return (v + half) >>> s;
    end else begin
      return -((-v + half) >>> s);
    end
  endfunction

  // Q40 sum to saturated Q16.16
  function automatic logic signed [31:0] sat_out(input logic signed [SUM_W-1:0] acc);
    logic signed [SUM_W-1:0] v;
    v = rnd_shift(acc, 24);
    if (v > 72'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -72'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

endpackage

`default_nettype wire

/* design/bsse_div.sv */
// Bit-serial restoring divider: round(num * 2^28 / den), half away from zero.
// Depends on bsse_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsse_div import bsse_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic signed [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0]        den,
  output logic                         done,
  output logic signed [31:0]           quot
);

  localparam int DSR_W = NUM_W + FRAC_STEPS;

  logic [DSR_W-1:0] dsr;
  logic [DEN_W-1:0] rem;
  logic [Q_W-1:0]   q;
  logic [6:0]       cnt;
  logic             running;
  logic             neg;

  logic [NUM_W-1:0] mag;
  logic [DEN_W:0]   rem_try;
  logic [Q_W-1:0]   q_rnd;

  always_comb begin
    mag     = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
    rem_try = {rem, dsr[DSR_W-1]};
    q_rnd   = (q + Q_W'(1)) >> 1;
    quot    = neg ? -$signed(q_rnd[31:0]) : $signed(q_rnd[31:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      dsr     <= {mag, {FRAC_STEPS{1'b0}}};
      rem     <= '0;
      q       <= '0;
      cnt     <= '0;
      neg     <= num[NUM_W-1];
      running <= 1'b1;
      done    <= 1'b0;
    end else if (running) begin
      dsr <= dsr << 1;
      if (rem_try >= {1'b0, den}) begin
        rem <= DEN_W'(rem_try - {1'b0, den});
        q   <= {q[Q_W-2:0], 1'b1};
      end else begin
        rem <= rem_try[DEN_W-1:0];
        q   <= {q[Q_W-2:0], 1'b0};
      end
      cnt <= cnt + 7'd1;
      if (cnt == 7'(DSR_W - 1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

endmodule

`default_nettype wire

/* design/beta_spline_segment_eval.sv */
// Cubic beta-spline segment evaluator: basis derivation and sample sequencer.
// Depends on bsse_pkg and bsse_div.
`timescale 1ns / 1ps
`default_nettype none

// A segment is taken when start is high and busy low. It yields n samples
// (n = the points register clamped to 3..MAX_SAMPLES), each on result for one
// cycle with result_valid; the receiver cannot stall, so results must be
// captured as they appear. All products go through one shared multiplier
// stepped by the sequencer: four basis terms of nine products each, each
// product passing through states S_MUL and S_ACC.
// After reset and after any write to a register the basis and step are
// rederived through a bit-serial divider (17 divisions of 85 steps), during
// which busy stays high.
module beta_spline_segment_eval import bsse_pkg::*; #(
  parameter int MAX_SAMPLES = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        start,
  output logic             busy,
  input  wire bsse_in_t    segment,
  output bsse_out_t        result,
  output logic             result_valid
);

  localparam logic [1:0] REG_BIAS    = 2'd0;
  localparam logic [1:0] REG_TENSION = 2'd1;
  localparam logic [1:0] REG_POINTS  = 2'd2;

  localparam logic [3:0] OP_H3 = 4'd0;
  localparam logic [3:0] OP_H2 = 4'd1;
  localparam logic [3:0] OP_H1 = 4'd2;
  localparam logic [3:0] OP_G3 = 4'd3;
  localparam logic [3:0] OP_G2 = 4'd4;
  localparam logic [3:0] OP_QX = 4'd5;
  localparam logic [3:0] OP_QY = 4'd6;
  localparam logic [3:0] OP_DX = 4'd7;
  localparam logic [3:0] OP_DY = 4'd8;

  typedef enum logic [3:0] {
    S_SQ, S_SQW, S_CUBE, S_CUBEW, S_LOAD, S_DIV, S_STEPL, S_STEPW,
    S_IDLE, S_MUL, S_ACC, S_OUT
  } state_t;

  state_t state;

  logic [15:0] bias;
  logic [15:0] tension;
  logic [6:0]  points;
  logic [31:0] sq;
  logic [47:0] cube;
  logic signed [31:0] coef [16];
  logic [31:0] step;
  logic [3:0]  idx;

  bsse_in_t pts;
  logic [CNT_W-1:0] cnt;
  logic [31:0] u;
  logic [1:0]  k;
  logic [3:0]  op;
  logic signed [HW-1:0]     acc;
  logic signed [HW-1:0]     w;
  logic signed [HW-1:0]     dw;
  logic signed [PROD_W-1:0] prod;
  logic signed [SUM_W-1:0]  qx, qy, dx, dy;

  logic [CNT_W-1:0]        n_smp;
  logic                    wr;
  logic                    cfg_hit;
  logic signed [HW-1:0]    mul_a;
  logic signed [MB_W-1:0]  mul_b;
  logic [1:0]              jsel;
  logic signed [HW-1:0]    cval;
  logic signed [HW-1:0]    cterm;
  logic signed [SUM_W-1:0] r28_full;
  logic signed [HW-1:0]    r28;
  logic signed [HW-1:0]    hsum;
  logic signed [SUM_W-1:0] rs4_full;
  logic signed [MB_W-1:0]  px;
  logic signed [MB_W-1:0]  py;
  logic signed [NUM_W-1:0] div_num;
  logic [DEN_W-1:0]        div_den;
  logic                    div_start;
  logic                    div_done;
  logic signed [31:0]      div_quot;
  logic signed [NUM_W-1:0] b3s, b2s, b1s, t2s, delta;

  localparam logic signed [NUM_W-1:0] ONE24 = 56'sd16777216;

  function automatic logic signed [NUM_W-1:0] numer(input logic [3:0] i,
                                                     input logic signed [NUM_W-1:0] b3,
                                                     input logic signed [NUM_W-1:0] b2,
                                                     input logic signed [NUM_W-1:0] b1,
                                                     input logic signed [NUM_W-1:0] t2);
    case (i)
      4'd0:    return 56'sd2 * b3;
      4'd1:    return 56'sd4 * (b2 + b1) + t2;
      4'd2:    return 56'sd2 * ONE24;
      4'd4:    return -56'sd6 * b3;
      4'd5:    return 56'sd6 * (b3 - b1);
      4'd6:    return 56'sd6 * b1;
      4'd8:    return 56'sd6 * b3;
      4'd9:    return -56'sd3 * (56'sd2 * b3 + 56'sd2 * b2 + t2);
      4'd10:   return 56'sd3 * (56'sd2 * b2 + t2);
      4'd12:   return -56'sd2 * b3;
      4'd13:   return 56'sd2 * (b3 + b2 + b1 + t2);
      4'd14:   return -56'sd2 * (b2 + b1 + t2 + ONE24);
      4'd15:   return 56'sd2 * ONE24;
      default: return '0;
    endcase
  endfunction

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign cfg_hit = wr && ((paddr[3:2] == REG_BIAS) || (paddr[3:2] == REG_TENSION) ||
                          (paddr[3:2] == REG_POINTS));
  assign busy    = (state != S_IDLE);

  always_comb begin
    case (paddr[3:2])
      REG_BIAS:    prdata = {16'b0, bias};
      REG_TENSION: prdata = {16'b0, tension};
      REG_POINTS:  prdata = {25'b0, points};
      default:     prdata = '0;
    endcase
  end

  always_comb begin
    if (points < 7'd3) begin
      n_smp = 7'd3;
    end else if (points > 7'(MAX_SAMPLES)) begin
      n_smp = 7'(MAX_SAMPLES);
    end else begin
      n_smp = points;
    end
  end

  // basis numerators and delta, all scaled by 2^24
  always_comb begin
    b3s     = $signed({8'b0, cube});
    b2s     = $signed({16'b0, sq, 8'b0});
    b1s     = $signed({24'b0, bias, 16'b0});
    t2s     = $signed({24'b0, tension, 16'b0});
    delta   = 56'sd2 * b3s + 56'sd4 * (b2s + b1s) + t2s + 56'sd2 * ONE24;
    div_start = (state == S_LOAD) || (state == S_STEPL);
    // the divider reads den every step, so hold it for the whole division
    if ((state == S_STEPL) || (state == S_STEPW)) begin
      div_num = 56'sd1;
      div_den = DEN_W'(n_smp - 7'd1);
    end else begin
      div_num = numer(idx, b3s, b2s, b1s, t2s);
      div_den = delta[DEN_W-1:0];
    end
  end

  always_comb begin
    case (k)
      2'd0:    begin px = MB_W'(pts.p1_x); py = MB_W'(pts.p1_y); end
      2'd1:    begin px = MB_W'(pts.p2_x); py = MB_W'(pts.p2_y); end
      2'd2:    begin px = MB_W'(pts.p3_x); py = MB_W'(pts.p3_y); end
      default: begin px = MB_W'(pts.p4_x); py = MB_W'(pts.p4_y); end
    endcase
  end

  // coefficient row for this step: c3 on the multiply, lower rows on the add
  always_comb begin
    if (state == S_MUL) begin
      jsel = 2'd3;
    end else begin
      case (op)
        OP_H3:   jsel = 2'd2;
        OP_H2:   jsel = 2'd1;
        OP_H1:   jsel = 2'd0;
        OP_G3:   jsel = 2'd2;
        OP_G2:   jsel = 2'd1;
        default: jsel = 2'd0;
      endcase
    end
    cval     = HW'(coef[{jsel, k}]);
    cterm    = (op == OP_G3) ? (cval <<< 1) : cval;
    r28_full = rnd_shift(SUM_W'(prod), 28);
    r28      = r28_full[HW-1:0];
    hsum     = r28 + cterm;
    rs4_full = rnd_shift(SUM_W'(hsum), 4);
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_SQ: begin
        mul_a = $signed(HW'(bias));
        mul_b = $signed(MB_W'(bias));
      end
      S_CUBE: begin
        mul_a = $signed(HW'(sq));
        mul_b = $signed(MB_W'(bias));
      end
      S_MUL: begin
        case (op)
          OP_H3:   begin mul_a = cval;             mul_b = $signed(MB_W'(u)); end
          OP_G3:   begin mul_a = cval * 38'sd3;    mul_b = $signed(MB_W'(u)); end
          OP_QX:   begin mul_a = w;                mul_b = px; end
          OP_QY:   begin mul_a = w;                mul_b = py; end
          OP_DX:   begin mul_a = dw;               mul_b = px; end
          OP_DY:   begin mul_a = dw;               mul_b = py; end
          default: begin mul_a = acc;              mul_b = $signed(MB_W'(u)); end
        endcase
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  bsse_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
    if (rst) begin
      state        <= S_SQ;
      bias         <= 16'd256;
      tension      <= 16'd0;
      points       <= 7'd16;
      result_valid <= 1'b0;
    end else begin
      result_valid <= (state == S_OUT) && !cfg_hit;
      if (cfg_hit) begin
        // any register write rederives basis and step
        state <= S_SQ;
      end else begin
        case (state)
          S_SQ:    state <= S_SQW;
          S_SQW: begin
            sq    <= prod[31:0];
            state <= S_CUBE;
          end
          S_CUBE:  state <= S_CUBEW;
          S_CUBEW: begin
            cube  <= prod[47:0];
            idx   <= '0;
            state <= S_LOAD;
          end
          S_LOAD:  state <= S_DIV;
          S_DIV: begin
            if (div_done) begin
              coef[idx] <= div_quot;
              idx       <= idx + 4'd1;
              state     <= (idx == 4'd15) ? S_STEPL : S_LOAD;
            end
          end
          S_STEPL: state <= S_STEPW;
          S_STEPW: begin
            if (div_done) begin
              step  <= div_quot;
              state <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (start) begin
              pts   <= segment;
              cnt   <= '0;
              u     <= '0;
              k     <= '0;
              op    <= OP_H3;
              qx    <= '0;
              qy    <= '0;
              dx    <= '0;
              dy    <= '0;
              state <= S_MUL;
            end
          end
          S_MUL:   state <= S_ACC;
          S_ACC: begin
            case (op)
              OP_H1:   w   <= rs4_full[HW-1:0];
              OP_G2:   dw  <= rs4_full[HW-1:0];
              OP_QX:   qx  <= qx + SUM_W'(prod);
              OP_QY:   qy  <= qy + SUM_W'(prod);
              OP_DX:   dx  <= dx + SUM_W'(prod);
              OP_DY:   dy  <= dy + SUM_W'(prod);
              default: acc <= hsum;
            endcase
            if (op == OP_DY) begin
              op <= OP_H3;
              k  <= k + 2'd1;
              state <= (k == 2'd3) ? S_OUT : S_MUL;
            end else begin
              op    <= op + 4'd1;
              state <= S_MUL;
            end
          end
          S_OUT: begin
            result.point_x      <= sat_out(qx);
            result.point_y      <= sat_out(qy);
            result.slope_x      <= sat_out(dx);
            result.slope_y      <= sat_out(dy);
            result.sample_index <= cnt[5:0];
            result.last_sample  <= (cnt + 7'd1 == n_smp);
            qx  <= '0;
            qy  <= '0;
            dx  <= '0;
            dy  <= '0;
            cnt <= cnt + 7'd1;
            u   <= u + step;
            state <= (cnt + 7'd1 == n_smp) ? S_IDLE : S_MUL;
          end
          default: state <= S_IDLE;
        endcase
      end
      if (wr) begin
        case (paddr[3:2])
          REG_BIAS:    bias    <= pwdata[15:0];
          REG_TENSION: tension <= pwdata[15:0];
          REG_POINTS:  points  <= pwdata[6:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

/* design/bsse_check.sv */
// Port-level checker for the beta-spline segment evaluator, bound to the top.
// Depends on bsse_pkg and beta_spline_segment_eval_assert.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "beta_spline_segment_eval_assert.svh"

module bsse_check import bsse_pkg::*; (
  input wire logic      clk,
  input wire logic      rst,
  input wire logic      start,
  input wire logic      busy,
  input wire logic      result_valid,
  input wire bsse_out_t result
);

  // a word mid-segment means more work follows
  `BSSE_ASSERT_IMP(a_mid_busy, result_valid && !result.last_sample, busy)
  // words are spaced by the sequencer, never adjacent
  `BSSE_ASSERT_NXT(a_no_burst, result_valid, !result_valid)
  // an accepted segment locks out the next
  `BSSE_ASSERT_NXT(a_take_busy, start && !busy, busy)
  // no word right after a segment is taken
  `BSSE_ASSERT_NXT(a_take_quiet, start && !busy, !result_valid)

endmodule

bind beta_spline_segment_eval bsse_check u_bsse_check (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .result       (result)
);

`default_nettype wire
